// File: rtl/core/port_rendezvous_matcher_defines.svh
`ifndef PORT_RENDEZVOUS_MATCHER_DEFINES_SVH
`define PORT_RENDEZVOUS_MATCHER_DEFINES_SVH

// clocked check, off during reset
`define PRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold
`define PRM_NEVER(lbl, cond, msg) \
	`PRM_ASSERT(lbl, !(cond), msg)

`endif

// File: rtl/core/prm_pkg.sv
package prm_pkg;

	localparam int PORT_W  = 16;
	localparam int PID_W   = 16;
	localparam int EP_W    = 8;
	localparam int ENTRY_W = PORT_W + PID_W + EP_W;

	localparam int BOUND_SLOTS_DEF   = 8;
	localparam int PENDING_SLOTS_DEF = 8;

	localparam logic [PORT_W-1:0] PRIV_LIMIT_RST = 16'd1024;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_LINK  = 1'b1;

	typedef enum logic [1:0] {
		OP_BIND    = 2'd0,
		OP_ACCEPT  = 2'd1,
		OP_CONNECT = 2'd2,
		OP_UNKNOWN = 2'd3
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	// request into a table: scan for a port, fill the free slot, release the matched slot
	typedef struct packed {
		logic              start;
		logic [PORT_W-1:0] port;
		logic              ins;
		logic              clr;
	} tbl_req_t;

	typedef struct packed {
		logic busy;
		logic hit;
		logic free;
	} tbl_sts_t;

endpackage

// File: rtl/core/prm_table.sv
`include "port_rendezvous_matcher_defines.svh"

module prm_table
	import prm_pkg::*;
#(
	parameter int DEPTH = PENDING_SLOTS_DEF,
	parameter int W     = ENTRY_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  tbl_req_t     req,
	input  logic [W-1:0] wr_data,
	output tbl_sts_t     sts,
	output logic [W-1:0] hit_data
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0]      mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;

	logic              active_q;
	logic              issue_q;
	logic [IW-1:0]     idx_q;
	logic [PORT_W-1:0] port_q;

	logic              vld_s1;
	logic              last_s1;
	logic [IW-1:0]     idx_s1;
	logic [W-1:0]      rdata_s1;

	logic              hit_q;
	logic              free_q;
	logic [IW-1:0]     hit_slot_q;
	logic [IW-1:0]     free_slot_q;
	logic [W-1:0]      hit_data_q;

	logic              ent_vld;
	logic              ent_match;
	logic              eval;
	logic              take_hit;
	logic              take_free;

	assign ent_vld   = vld_q[idx_s1];
	assign ent_match = ent_vld && (rdata_s1[PORT_W-1:0] == port_q);
	assign eval      = active_q && vld_s1 && !req.start;
	assign take_hit  = eval && ent_match && !hit_q;
	assign take_free = eval && !ent_vld && !free_q;

	// memory port
	always_ff @(posedge clk) begin
		if (req.ins) begin
			mem[free_slot_q] <= wr_data;
		end
		rdata_s1 <= mem[idx_q];
		idx_s1   <= idx_q;
		last_s1  <= (idx_q == IW'(DEPTH - 1));
		if (req.start) begin
			port_q <= req.port;
		end
		if (take_hit) begin
			hit_slot_q <= idx_s1;
			hit_data_q <= rdata_s1;
		end
		if (take_free) begin
			free_slot_q <= idx_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			issue_q  <= 1'b0;
			idx_q    <= '0;
			vld_s1   <= 1'b0;
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			vld_q    <= '0;
		end else begin
			if (req.start) begin
				active_q <= 1'b1;
				issue_q  <= 1'b1;
				idx_q    <= '0;
				vld_s1   <= 1'b0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				vld_s1 <= issue_q;
				if (issue_q) begin
					if (idx_q == IW'(DEPTH - 1)) begin
						issue_q <= 1'b0;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				if (take_hit) begin
					hit_q <= 1'b1;
				end
				if (take_free) begin
					free_q <= 1'b1;
				end
				if (eval && last_s1) begin
					active_q <= 1'b0;
				end
			end
			if (req.ins) begin
				vld_q[free_slot_q] <= 1'b1;
			end
			if (req.clr) begin
				vld_q[hit_slot_q] <= 1'b0;
			end
		end
	end

	assign sts.busy = active_q;
	assign sts.hit  = hit_q;
	assign sts.free = free_q;
	assign hit_data = hit_data_q;

	`PRM_ASSERT(a_ins_free, req.ins |-> (free_q && !active_q), "fill without a free slot")
	`PRM_ASSERT(a_clr_hit, req.clr |-> (hit_q && !active_q), "release without a match")
	`PRM_NEVER(a_start_busy, req.start && active_q, "scan restarted while running")

endmodule

// File: rtl/core/port_rendezvous_matcher.sv
// channel   | handshake         | payload
// request   | start / busy      | op, port, requester, endpoint, is_root
// result    | done (strobe)     | kind, failed, reply_port, target_pid, client_endpoint,
//           |                   | server_pid, server_endpoint
// config    | cfg_we            | cfg_wdata (privileged limit)
//
// an unknown op or a refused privileged bind answers in the cycle after acceptance
// all other requests scan the three tables side by side, one memory read a cycle
// busy is high while a scan runs; results are a one-cycle strobe, never stalled
// reset clears the valid bits and the control state; no clearing pass is needed
`include "port_rendezvous_matcher_defines.svh"

module port_rendezvous_matcher
	import prm_pkg::*;
#(
	parameter int BOUND_SLOTS   = BOUND_SLOTS_DEF,
	parameter int PENDING_SLOTS = PENDING_SLOTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        op,
	input  logic [PORT_W-1:0] port,
	input  logic [PID_W-1:0]  requester,
	input  logic [EP_W-1:0]   endpoint,
	input  logic              is_root,
	input  logic              cfg_we,
	input  logic [PORT_W-1:0] cfg_wdata,
	output logic              done,
	output logic              kind,
	output logic              failed,
	output logic [PORT_W-1:0] reply_port,
	output logic [PID_W-1:0]  target_pid,
	output logic [EP_W-1:0]   client_endpoint,
	output logic [PID_W-1:0]  server_pid,
	output logic [EP_W-1:0]   server_endpoint
);

	state_t             state_q, state_d;
	op_t                op_in;
	op_t                op_q;
	logic [PORT_W-1:0]  port_q;
	logic [PID_W-1:0]   pid_q;
	logic [EP_W-1:0]    ep_q;
	logic [PORT_W-1:0]  lim_q;

	logic               take;
	logic               priv_deny;
	logic               scan_busy;
	logic [ENTRY_W-1:0] own_entry;

	tbl_req_t           b_req, a_req, c_req;
	tbl_sts_t           b_sts, a_sts, c_sts;
	logic [ENTRY_W-1:0] a_data, c_data;

	logic               res_load;
	logic               res_kind;
	logic               res_failed;
	logic [PORT_W-1:0]  res_port;
	logic [PID_W-1:0]   res_tpid;
	logic [EP_W-1:0]    res_cep;
	logic [PID_W-1:0]   res_spid;
	logic [EP_W-1:0]    res_sep;
	logic               go;

	logic               done_q;
	logic               kind_q;
	logic               failed_q;
	logic [PORT_W-1:0]  rport_q;
	logic [PID_W-1:0]   tpid_q;
	logic [EP_W-1:0]    cep_q;
	logic [PID_W-1:0]   spid_q;
	logic [EP_W-1:0]    sep_q;

	assign op_in     = op_t'(op);
	assign take      = start && (state_q == ST_IDLE);
	assign priv_deny = (port < lim_q) && !is_root;
	assign scan_busy = b_sts.busy || a_sts.busy || c_sts.busy;
	assign own_entry = {ep_q, pid_q, port_q};

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					if (op_in inside {OP_ACCEPT, OP_CONNECT} || (op_in == OP_BIND && !priv_deny)) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (!scan_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		go         = 1'b0;
		b_req      = '0;
		a_req      = '0;
		c_req      = '0;
		res_load   = 1'b0;
		res_kind   = KIND_REPLY;
		res_failed = 1'b0;
		res_port   = port_q;
		res_tpid   = pid_q;
		res_cep    = '0;
		res_spid   = '0;
		res_sep    = '0;
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					res_port = port;
					res_tpid = requester;
					case (op_in)
						OP_BIND: begin
							if (priv_deny) begin
								res_load   = 1'b1;
								res_failed = 1'b1;
							end else begin
								go = 1'b1;
							end
						end
						OP_ACCEPT, OP_CONNECT: go = 1'b1;
						default: begin
							res_load   = 1'b1;
							res_failed = 1'b1;
							res_port   = '0;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!scan_busy) begin
					case (op_q)
						OP_BIND: begin
							res_load = 1'b1;
							if (!b_sts.hit) begin
								if (b_sts.free) begin
									b_req.ins = 1'b1;
								end else begin
									res_failed = 1'b1;
								end
							end
						end
						OP_ACCEPT: begin
							if (c_sts.hit) begin
								c_req.clr = 1'b1;
								res_load  = 1'b1;
								res_kind  = KIND_LINK;
								res_tpid  = c_data[PORT_W+PID_W-1:PORT_W];
								res_cep   = c_data[ENTRY_W-1:PORT_W+PID_W];
								res_spid  = pid_q;
								res_sep   = ep_q;
							end else if (a_sts.free) begin
								a_req.ins = 1'b1;
							end else begin
								res_load   = 1'b1;
								res_failed = 1'b1;
							end
						end
						OP_CONNECT: begin
							if (!b_sts.hit) begin
								res_load   = 1'b1;
								res_failed = 1'b1;
							end else if (a_sts.hit) begin
								a_req.clr = 1'b1;
								res_load  = 1'b1;
								res_kind  = KIND_LINK;
								res_tpid  = pid_q;
								res_cep   = ep_q;
								res_spid  = a_data[PORT_W+PID_W-1:PORT_W];
								res_sep   = a_data[ENTRY_W-1:PORT_W+PID_W];
							end else if (c_sts.free) begin
								c_req.ins = 1'b1;
							end else begin
								res_load   = 1'b1;
								res_failed = 1'b1;
							end
						end
						default: res_load = 1'b0;
					endcase
				end
			end
			default: go = 1'b0;
		endcase
		b_req.start = go;
		a_req.start = go;
		c_req.start = go;
		b_req.port  = port;
		a_req.port  = port;
		c_req.port  = port;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			lim_q   <= PRIV_LIMIT_RST;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_load;
			if (cfg_we) begin
				lim_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q   <= op_in;
			port_q <= port;
			pid_q  <= requester;
			ep_q   <= endpoint;
		end
		if (res_load) begin
			kind_q   <= res_kind;
			failed_q <= res_failed;
			rport_q  <= res_port;
			tpid_q   <= res_tpid;
			cep_q    <= res_cep;
			spid_q   <= res_spid;
			sep_q    <= res_sep;
		end
	end

	prm_table #(
		.DEPTH (BOUND_SLOTS),
		.W     (PORT_W)
	) u_bound (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (b_req),
		.wr_data  (port_q),
		.sts      (b_sts),
		.hit_data ()
	);

	prm_table #(
		.DEPTH (PENDING_SLOTS),
		.W     (ENTRY_W)
	) u_accept (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (a_req),
		.wr_data  (own_entry),
		.sts      (a_sts),
		.hit_data (a_data)
	);

	prm_table #(
		.DEPTH (PENDING_SLOTS),
		.W     (ENTRY_W)
	) u_connect (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (c_req),
		.wr_data  (own_entry),
		.sts      (c_sts),
		.hit_data (c_data)
	);

	assign busy            = (state_q != ST_IDLE);
	assign done            = done_q;
	assign kind            = kind_q;
	assign failed          = failed_q;
	assign reply_port      = rport_q;
	assign target_pid      = tpid_q;
	assign client_endpoint = cep_q;
	assign server_pid      = spid_q;
	assign server_endpoint = sep_q;

	`PRM_NEVER(a_done_in_scan, done_q && (state_q == ST_SCAN), "result while scanning")
	`PRM_ASSERT(a_fail_reply, (done_q && failed_q) |-> (kind_q == KIND_REPLY), "failed link order")
	`PRM_ASSERT(a_accept_scans, (start && !busy && (op == OP_ACCEPT)) |=> busy, "accept did not scan")

endmodule
